>>> sv/note_token_parser_macros.svh
// Assertion macros used by note_token_parser to check its own behaviour.
// Both macros expect signals named aclk and aresetn in the enclosing scope.
`ifndef NOTE_TOKEN_PARSER_MACROS_SVH
`define NOTE_TOKEN_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ntp_pkg.sv
package ntp_pkg;

    localparam int NOTE_VALUE_BITS = 16;
    localparam int CHAR_W          = 8;
    localparam int TEMPO_W         = 10;
    localparam int OCT_W           = 3;
    localparam int DIGIT_W         = 4;
    localparam int SHIFT_W         = 5;
    localparam int LETTER_W        = 3;
    localparam int BASE_W          = 15;
    localparam int PROD_W          = TEMPO_W + NOTE_VALUE_BITS;
    localparam int VALUE_ACC_W     = NOTE_VALUE_BITS + 4;
    localparam int DUR_W           = 24;
    localparam int CNT_W           = $clog2(DUR_W);
    localparam int FREQ_W          = 31;
    localparam int M_TDATA_W       = ((DUR_W + FREQ_W + 7) / 8) * 8;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 10;

    localparam logic [DUR_W-1:0]     DUR_CONST       = 24'd10560000;
    localparam logic [DUR_W-1:0]     DUR_MAX         = 24'd15840000;
    localparam logic [TEMPO_W-1:0]   TEMPO_RESET     = 10'd120;
    localparam logic [OCT_W-1:0]     OCTAVE_RESET    = 3'd0;
    localparam logic [BASE_W-1:0]    UNKNOWN_CENTIHZ = 15'd100;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OCTAVE = 8'd1;

    localparam logic [CHAR_W-1:0]    CH_SPACE        = 8'h20;
    localparam logic [CHAR_W-1:0]    CH_DOT          = 8'h2E;
    localparam logic [CHAR_W-1:0]    CH_SHARP        = 8'h23;
    localparam logic [CHAR_W-1:0]    CH_FLAT         = 8'h62;
    localparam logic [CHAR_W-1:0]    CH_ZERO         = 8'h30;
    localparam logic [CHAR_W-1:0]    CH_NINE         = 8'h39;

    typedef enum logic [1:0] {
        ACC_NATURAL,
        ACC_SHARP,
        ACC_FLAT
    } acc_t;

    typedef struct packed {
        logic [NOTE_VALUE_BITS-1:0] note_value;
        logic                       dotted;
        logic [BASE_W-1:0]          base_centihz;
        logic [SHIFT_W-1:0]         shift;
        logic                       known;
        logic                       error;
    } note_req_t;

    typedef struct packed {
        logic [DUR_W-1:0]  duration;
        logic [FREQ_W-1:0] freq;
        logic              known;
        logic              error;
    } note_res_t;

    function automatic logic [BASE_W-1:0] note_base(input logic [LETTER_W-1:0] idx,
                                                    input acc_t acc);
        logic [BASE_W-1:0] nat;
        logic [BASE_W-1:0] shp;
        logic [BASE_W-1:0] flt;
        case (idx)
            3'd0: begin
                nat = 15'd13080; shp = 15'd13860; flt = 15'd12350;
            end
            3'd1: begin
                nat = 15'd14685; shp = 15'd15555; flt = 15'd13860;
            end
            3'd2: begin
                nat = 15'd16480; shp = 15'd17460; flt = 15'd15555;
            end
            3'd3: begin
                nat = 15'd17460; shp = 15'd18500; flt = 15'd16480;
            end
            3'd4: begin
                nat = 15'd19600; shp = 15'd20765; flt = 15'd18500;
            end
            3'd5: begin
                nat = 15'd22000; shp = 15'd23310; flt = 15'd20765;
            end
            default: begin
                nat = 15'd24695; shp = 15'd26160; flt = 15'd23310;
            end
        endcase
        case (acc)
            ACC_SHARP: return shp;
            ACC_FLAT:  return flt;
            default:   return nat;
        endcase
    endfunction

    // Returns the hit flag above the letter index.
    function automatic logic [LETTER_W:0] letter_decode(input logic [CHAR_W-1:0] c);
        case (c)
            "C":     return {1'b1, 3'd0};
            "D":     return {1'b1, 3'd1};
            "E":     return {1'b1, 3'd2};
            "F":     return {1'b1, 3'd3};
            "G":     return {1'b1, 3'd4};
            "A":     return {1'b1, 3'd5};
            "H":     return {1'b1, 3'd6};
            "B":     return {1'b1, 3'd7};
            default: return {1'b0, 3'd0};
        endcase
    endfunction

endpackage

>>> sv/ntp_parse.sv
module ntp_parse (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  logic [ntp_pkg::CHAR_W-1:0]      char_code,
    input  logic                            line_break,
    input  logic [ntp_pkg::OCT_W-1:0]       base_octave,
    output logic                            emit,
    output ntp_pkg::note_req_t              req
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_DIGITS,
        PH_LETTER,
        PH_ACCID,
        PH_OCTAVE,
        PH_SKIP
    } phase_t;

    phase_t                                 phase_reg, phase_next;
    logic [ntp_pkg::NOTE_VALUE_BITS-1:0]    value_reg, value_next;
    logic                                   dotted_reg, dotted_next;
    logic [ntp_pkg::BASE_W-1:0]             base_reg, base_next;
    logic [ntp_pkg::LETTER_W-1:0]           letter_reg, letter_next;
    logic                                   known_reg, known_next;
    logic                                   error_reg, error_next;

    logic                                   is_digit;
    logic [ntp_pkg::DIGIT_W-1:0]            digit;
    logic [ntp_pkg::LETTER_W:0]             letter_code;
    logic [ntp_pkg::VALUE_ACC_W-1:0]        value_acc;
    logic [ntp_pkg::NOTE_VALUE_BITS-1:0]    value_sat;
    logic [ntp_pkg::DIGIT_W-1:0]            emit_shift;
    logic                                   emit_bad;

    assign is_digit    = char_code inside {[ntp_pkg::CH_ZERO:ntp_pkg::CH_NINE]};
    assign digit       = ntp_pkg::DIGIT_W'(char_code - ntp_pkg::CH_ZERO);
    assign letter_code = ntp_pkg::letter_decode(char_code);
    assign value_acc   = (ntp_pkg::VALUE_ACC_W'(value_reg) << 3)
                         + (ntp_pkg::VALUE_ACC_W'(value_reg) << 1)
                         + ntp_pkg::VALUE_ACC_W'(digit);
    assign value_sat   = (value_acc > ntp_pkg::VALUE_ACC_W'({ntp_pkg::NOTE_VALUE_BITS{1'b1}}))
                         ? {ntp_pkg::NOTE_VALUE_BITS{1'b1}}
                         : value_acc[ntp_pkg::NOTE_VALUE_BITS-1:0];

    always_comb begin
        phase_next  = phase_reg;
        value_next  = value_reg;
        dotted_next = dotted_reg;
        base_next   = base_reg;
        letter_next = letter_reg;
        known_next  = known_reg;
        error_next  = error_reg;
        emit        = 1'b0;
        emit_shift  = '0;
        emit_bad    = 1'b0;
        if (step) begin
            if (line_break) begin
                phase_next = PH_FIRST;
                if (phase_reg == PH_ACCID || phase_reg == PH_OCTAVE) begin
                    emit = 1'b1;
                end
            end else begin
                case (phase_reg)
                    PH_DIGITS, PH_LETTER: begin
                        if (phase_reg == PH_DIGITS && is_digit) begin
                            value_next = value_sat;
                        end else if (phase_reg == PH_DIGITS
                                     && char_code == ntp_pkg::CH_DOT) begin
                            dotted_next = 1'b1;
                            phase_next  = PH_LETTER;
                        end else if (letter_code[ntp_pkg::LETTER_W]) begin
                            letter_next = letter_code[ntp_pkg::LETTER_W-1:0];
                            base_next   = ntp_pkg::note_base(
                                              letter_code[ntp_pkg::LETTER_W-1:0],
                                              ntp_pkg::ACC_NATURAL);
                            known_next  = 1'b1;
                            phase_next  = PH_ACCID;
                        end else begin
                            letter_next = '0;
                            base_next   = ntp_pkg::UNKNOWN_CENTIHZ;
                            known_next  = 1'b0;
                            phase_next  = PH_OCTAVE;
                        end
                    end
                    PH_ACCID, PH_OCTAVE: begin
                        if (phase_reg == PH_ACCID
                            && (char_code == ntp_pkg::CH_SHARP
                                || char_code == ntp_pkg::CH_FLAT)) begin
                            base_next  = ntp_pkg::note_base(letter_reg,
                                             (char_code == ntp_pkg::CH_SHARP)
                                             ? ntp_pkg::ACC_SHARP : ntp_pkg::ACC_FLAT);
                            phase_next = PH_OCTAVE;
                        end else begin
                            emit = 1'b1;
                            if (char_code == ntp_pkg::CH_SPACE) begin
                                phase_next = PH_FIRST;
                            end else if (is_digit) begin
                                emit_shift = digit;
                                phase_next = PH_SKIP;
                            end else begin
                                emit_bad   = 1'b1;
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        phase_next = PH_FIRST;
                    end
                    default: begin
                        dotted_next = 1'b0;
                        known_next  = 1'b0;
                        base_next   = '0;
                        letter_next = '0;
                        value_next  = is_digit ? ntp_pkg::NOTE_VALUE_BITS'(digit) : '0;
                        error_next  = !is_digit;
                        phase_next  = PH_DIGITS;
                    end
                endcase
            end
        end
    end

    always_comb begin
        req.note_value   = value_reg;
        req.dotted       = dotted_reg;
        req.base_centihz = base_reg;
        req.shift        = ntp_pkg::SHIFT_W'(emit_shift)
                           + (known_reg ? ntp_pkg::SHIFT_W'(base_octave) : '0);
        req.known        = known_reg;
        req.error        = error_reg | emit_bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
        end else begin
            phase_reg <= phase_next;
        end
        value_reg  <= value_next;
        dotted_reg <= dotted_next;
        base_reg   <= base_next;
        letter_reg <= letter_next;
        known_reg  <= known_next;
        error_reg  <= error_next;
    end

endmodule

>>> sv/ntp_div.sv
module ntp_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  ntp_pkg::note_req_t              req,
    input  logic [ntp_pkg::TEMPO_W-1:0]     tempo,
    input  logic                            res_ready,
    output logic                            busy,
    output logic                            res_valid,
    output ntp_pkg::note_res_t              res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

    state_t                                 state_reg;
    logic [ntp_pkg::NOTE_VALUE_BITS-1:0]    value_reg;
    logic [ntp_pkg::TEMPO_W-1:0]            tempo_reg;
    logic                                   dotted_reg;
    logic [ntp_pkg::BASE_W-1:0]             base_reg;
    logic [ntp_pkg::SHIFT_W-1:0]            shift_reg;
    logic                                   known_reg;
    logic                                   error_reg;
    logic [ntp_pkg::PROD_W-1:0]             prod_reg;
    logic [ntp_pkg::PROD_W-1:0]             rem_reg;
    logic [ntp_pkg::DUR_W-1:0]              quot_reg;
    logic [ntp_pkg::CNT_W-1:0]              cnt_reg;
    logic [ntp_pkg::FREQ_W-1:0]             freq_reg;
    ntp_pkg::note_res_t                     res_reg;

    logic [ntp_pkg::PROD_W:0]               rem_shift;
    logic                                   fits;
    logic [ntp_pkg::PROD_W:0]               rem_step;
    logic                                   fix_error;

    // One restoring division step: bring down the next dividend bit and subtract if it fits.
    assign rem_shift = {rem_reg, ntp_pkg::DUR_CONST[cnt_reg]};
    assign fits      = rem_shift >= {1'b0, prod_reg};
    assign rem_step  = fits ? rem_shift - {1'b0, prod_reg} : rem_shift;
    assign fix_error = error_reg | (prod_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                value_reg  <= req.note_value;
                tempo_reg  <= tempo;
                dotted_reg <= req.dotted;
                base_reg   <= req.base_centihz;
                shift_reg  <= req.shift;
                known_reg  <= req.known;
                error_reg  <= req.error;
            end
            ST_MUL: begin
                prod_reg <= ntp_pkg::PROD_W'(tempo_reg) * ntp_pkg::PROD_W'(value_reg);
                freq_reg <= ntp_pkg::FREQ_W'(base_reg) << shift_reg;
                rem_reg  <= '0;
                quot_reg <= '0;
                cnt_reg  <= ntp_pkg::CNT_W'(ntp_pkg::DUR_W - 1);
            end
            ST_DIV: begin
                rem_reg  <= rem_step[ntp_pkg::PROD_W-1:0];
                quot_reg <= {quot_reg[ntp_pkg::DUR_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            ST_FIX: begin
                res_reg.duration <= fix_error ? '0
                                  : (dotted_reg ? quot_reg + (quot_reg >> 1) : quot_reg);
                res_reg.freq     <= freq_reg;
                res_reg.known    <= known_reg;
                res_reg.error    <= fix_error;
            end
            default: begin
            end
        endcase
    end

    assign busy      = state_reg != ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign res       = res_reg;

endmodule

>>> sv/note_token_parser.sv
// Channel   Direction  Payload
// s_        in         tdata: char_code; tuser: line_break
// m_        out        tdata: duration_samples, freq_centihz; tuser: note_known, parse_error
// cfg_      in         cfg_index selects tempo (0) or base_octave (1), cfg_data holds the value
//
// A character that completes no note is accepted whenever the divider is idle.
// A character that completes a note keeps s_tready low while the divider works
// (one multiply, 24 restoring subtract steps, one finishing step, one hand-over).
// The output register lets a finished note wait on m_tready while plain characters are taken.
// A note that finishes while that register is still full holds s_tready low until it drains.
// Reset is synchronous and active low; it restores tempo 120 and base octave 0.
`include "note_token_parser_macros.svh"

module note_token_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ntp_pkg::CHAR_W-1:0]          s_tdata,   // char_code
    input  logic                                s_tuser,   // line_break
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ntp_pkg::M_TDATA_W-1:0]       m_tdata,   // duration_samples, freq_centihz
    output logic [1:0]                          m_tuser,   // note_known, parse_error
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ntp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ntp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [ntp_pkg::TEMPO_W-1:0]        tempo_reg;
    logic [ntp_pkg::OCT_W-1:0]          base_octave_reg;
    logic                               m_tvalid_reg;
    logic [ntp_pkg::M_TDATA_W-1:0]      m_tdata_reg;
    logic [1:0]                         m_tuser_reg;

    logic                               step;
    logic                               start;
    logic                               div_busy;
    logic                               res_valid;
    logic                               out_free;
    logic                               load;
    ntp_pkg::note_req_t                 req;
    ntp_pkg::note_res_t                 res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !div_busy;
    assign step      = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign load      = res_valid && out_free;

    ntp_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .char_code   (s_tdata),
        .line_break  (s_tuser),
        .base_octave (base_octave_reg),
        .emit        (start),
        .req         (req)
    );

    ntp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req       (req),
        .tempo     (tempo_reg),
        .res_ready (out_free),
        .busy      (div_busy),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tempo_reg       <= ntp_pkg::TEMPO_RESET;
            base_octave_reg <= ntp_pkg::OCTAVE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ntp_pkg::REG_TEMPO: begin
                    tempo_reg <= cfg_data[ntp_pkg::TEMPO_W-1:0];
                end
                ntp_pkg::REG_BASE_OCTAVE: begin
                    base_octave_reg <= cfg_data[ntp_pkg::OCT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (load) begin
            m_tdata_reg <= ntp_pkg::M_TDATA_W'({res.freq, res.duration});
            m_tuser_reg <= {res.error, res.known};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `NTP_ASSERT_NOW(a_error_zero_duration, m_tvalid_reg && m_tuser_reg[1],
                    m_tdata_reg[ntp_pkg::DUR_W-1:0] == '0,
                    "flagged note carries a nonzero duration")
    `NTP_ASSERT_NOW(a_duration_bound, m_tvalid_reg,
                    m_tdata_reg[ntp_pkg::DUR_W-1:0] <= ntp_pkg::DUR_MAX,
                    "duration exceeds the dotted whole-note limit")
    `NTP_ASSERT_NEXT(a_busy_after_start, start, !s_tready,
                     "input accepted while the divider works on a note")

endmodule
